// ----- rtl/nirpd_pkg.sv -----
// Package for the NEC IR pulse decoder: request codes, interval windows,
// classification and state-view types. No dependencies.
`default_nettype none

package nirpd_pkg;

  localparam int IntervalW = 16;
  localparam int ByteW     = 8;

  typedef enum logic [1:0] {
    REQ_EDGE    = 2'd0,
    REQ_TIMEOUT = 2'd1,
    REQ_CONSUME = 2'd2
  } req_t;

  // Interval windows in timer ticks
  localparam logic [IntervalW-1:0] LEADER_LO     = 16'd850;
  localparam logic [IntervalW-1:0] LEADER_HI     = 16'd999;
  localparam logic [IntervalW-1:0] MARK_LO       = 16'd40;
  localparam logic [IntervalW-1:0] MARK_HI       = 16'd69;
  localparam logic [IntervalW-1:0] START_LO      = 16'd420;
  localparam logic [IntervalW-1:0] START_HI      = 16'd479;
  localparam logic [IntervalW-1:0] REPEAT_LO     = 16'd200;
  localparam logic [IntervalW-1:0] REPEAT_HI     = 16'd259;
  localparam logic [IntervalW-1:0] BIT_LO        = 16'd40;
  localparam logic [IntervalW-1:0] BIT_HI        = 16'd179;
  localparam logic [IntervalW-1:0] BIT_ONE_ABOVE = 16'd100;

  localparam logic [ByteW-1:0] FRAME_BITS = 8'd32;
  localparam logic [ByteW-1:0] START_POS  = 8'd255;

  typedef struct packed {
    logic leader;
    logic mark;
    logic start;
    logic rpt;
    logic bitw;
    logic one;
  } win_t;

  typedef struct packed {
    logic             ready;
    logic [ByteW-1:0] rpt_cnt;
    logic [ByteW-1:0] cmd_inv;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] addr_cpl;
    logic [ByteW-1:0] addr;
  } dec_view_t;

endpackage

`default_nettype wire

// ----- rtl/nirpd_classify.sv -----
// Interval window classifier for the NEC IR pulse decoder.
// Depends on nirpd_pkg.
`default_nettype none

module nirpd_classify (
  input  wire logic [nirpd_pkg::IntervalW-1:0] interval,
  output nirpd_pkg::win_t                      win
);
  import nirpd_pkg::*;

  always_comb begin
    win.leader = (interval >= LEADER_LO) && (interval <= LEADER_HI);
    win.mark   = (interval >= MARK_LO)   && (interval <= MARK_HI);
    win.start  = (interval >= START_LO)  && (interval <= START_HI);
    win.rpt    = (interval >= REPEAT_LO) && (interval <= REPEAT_HI);
    win.bitw   = (interval >= BIT_LO)    && (interval <= BIT_HI);
    win.one    = interval > BIT_ONE_ABOVE;
  end

endmodule

`default_nettype wire

// ----- rtl/nirpd_decoder.sv -----
// Decoder state (bytes, bit position, leader, repeat count, ready) and its
// per-transaction update. Depends on nirpd_pkg.
`default_nettype none

module nirpd_decoder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            enable_ir,
  input  wire logic            upd,
  input  nirpd_pkg::req_t      req,
  input  wire logic            level,
  input  nirpd_pkg::win_t      win,
  output nirpd_pkg::dec_view_t view_nxt
);
  import nirpd_pkg::*;

  logic [3:0][ByteW-1:0] bytes_r, bytes_nxt;
  logic [ByteW-1:0]      pos_r, pos_nxt;
  logic                  leader_r, leader_nxt;
  logic [ByteW-1:0]      rpt_r, rpt_nxt;
  logic                  rdy_r, rdy_nxt;

  always_comb begin
    bytes_nxt  = bytes_r;
    pos_nxt    = pos_r;
    leader_nxt = leader_r;
    rpt_nxt    = rpt_r;
    rdy_nxt    = rdy_r;
    case (req)
      REQ_EDGE: begin
        if (enable_ir) begin
          if (level) begin
            if (win.leader) begin
              leader_nxt = 1'b1;
              rdy_nxt    = 1'b0;
            end else if (win.mark) begin
              pos_nxt = pos_r + 8'd1;
            end
          end else begin
            if (win.start) begin
              if (leader_r) begin
                pos_nxt    = START_POS;
                rpt_nxt    = '0;
                leader_nxt = 1'b0;
              end
            end else if (win.rpt) begin
              if (leader_r) begin
                pos_nxt    = START_POS;
                leader_nxt = 1'b0;
                rpt_nxt    = rpt_r + 8'd1;
                rdy_nxt    = 1'b1;
              end
            end else if (win.bitw) begin
              // only positions 0..31 land in a byte
              if (pos_r[7:5] == 3'd0) begin
                bytes_nxt[pos_r[4:3]][pos_r[2:0]] = win.one;
              end
            end
          end
          if (pos_nxt == FRAME_BITS) begin
            rdy_nxt = 1'b1;
          end
        end
      end
      REQ_TIMEOUT: begin
        if (enable_ir) begin
          bytes_nxt  = '0;
          pos_nxt    = '0;
          leader_nxt = 1'b0;
          rpt_nxt    = '0;
          rdy_nxt    = 1'b0;
        end
      end
      REQ_CONSUME: begin
        rdy_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r  <= '0;
      pos_r    <= '0;
      leader_r <= 1'b0;
      rpt_r    <= '0;
      rdy_r    <= 1'b0;
    end else if (upd) begin
      bytes_r  <= bytes_nxt;
      pos_r    <= pos_nxt;
      leader_r <= leader_nxt;
      rpt_r    <= rpt_nxt;
      rdy_r    <= rdy_nxt;
    end
  end

  always_comb begin
    view_nxt.addr     = bytes_nxt[0];
    view_nxt.addr_cpl = bytes_nxt[1];
    view_nxt.cmd      = bytes_nxt[2];
    view_nxt.cmd_inv  = bytes_nxt[3];
    view_nxt.rpt_cnt  = rpt_nxt;
    view_nxt.ready    = rdy_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/nec_ir_pulse_decoder_top.sv -----
// NEC IR pulse decoder top level: input register, decoder, result register.
// Depends on nirpd_pkg, nirpd_classify, nirpd_decoder.
//
// Usage:
//   in_*  : one request per transaction. in_tuser = req_type (edge, timeout,
//           consume). in_tdata = {interval, level}.
//   out_* : one result per request, the decoder state after that request.
//   cfg_* : write of enable_ir; always ready, take it only while idle.
// Update: the result register loads, as the state updates, when the request
// moves out of the input register (result register empty or out_tready high).
// Throughput: one request per cycle while out_tready is high; back-to-back
// requests see each other's effect on the decoder state with no bubble.
// Reset: all decoder state clears, enable_ir returns to 1, both stages empty.
// Stall: while out_tready is low the result holds; one more request sits in
// the input register, then in_tready drops until the result is taken.
`default_nettype none

module nec_ir_pulse_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [0] level, [16:1] interval, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] address, [15:8] address_inverted,
                                       // [23:16] command, [31:24] command_inverted,
                                       // [39:32] repeat_count, [40] frame_ready
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import nirpd_pkg::*;

  logic                 enable_ir_r;
  logic                 s1_valid_r;
  req_t                 s1_req_r;
  logic                 s1_level_r;
  logic [IntervalW-1:0] s1_interval_r;
  logic                 out_tvalid_r;
  logic [47:0]          out_tdata_r;
  logic                 s1_move;
  win_t                 win;
  dec_view_t            view_nxt;

  assign cfg_ready  = 1'b1;
  assign s1_move    = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_move;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_ir_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable_ir_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r      <= req_t'(in_tuser);
      s1_level_r    <= in_tdata[0];
      s1_interval_r <= in_tdata[16:1];
    end
  end

  nirpd_classify u_classify (
    .interval (s1_interval_r),
    .win      (win)
  );

  nirpd_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable_ir (enable_ir_r),
    .upd       (s1_move),
    .req       (s1_req_r),
    .level     (s1_level_r),
    .win       (win),
    .view_nxt  (view_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_move) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_tdata_r <= {7'd0, view_nxt.ready, view_nxt.rpt_cnt, view_nxt.cmd_inv,
                      view_nxt.cmd, view_nxt.addr_cpl, view_nxt.addr};
    end
  end

  // a consume transaction always yields frame_ready low
  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (s1_req_r == REQ_CONSUME) |=> !out_tdata_r[40])
    else $error("consume did not clear frame_ready");

  // an enabled timeout yields an all-zero result
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (s1_req_r == REQ_TIMEOUT) && enable_ir_r |=> (out_tdata_r == '0))
    else $error("timeout did not clear decoder state");

  // an empty input register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty input register");

  // a pending result is not overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |-> !s1_move)
    else $error("result register overwritten during stall");

endmodule

`default_nettype wire
